/* design/tae_pkg.sv */
// shared types and constants of the tar archive stream extractor
package tae_pkg;

    localparam int BLOCK_BYTES    = 512;
    localparam int OFF_W          = 9;
    localparam int SIZE_BITS      = 33;
    localparam int NAME_BYTES_DEF = 256;
    localparam int NAME_FIELD_LEN = 100;
    localparam int SIZE_OFF       = 124;
    localparam int SIZE_DIGITS    = 11;
    localparam int TYPE_OFF       = 156;
    localparam int PREFIX_OFF     = 345;
    localparam int PREFIX_LEN     = 155;
    localparam int CHUNK_BYTES    = 8;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LONG  = 8'h4C;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_NAME  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // what an item in the queue asks of the back end
    typedef enum logic {
        OP_HDR,
        OP_CONTENT
    } op_t;

    // decision taken on the last byte of a header block
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_END,
        ACT_LONG,
        ACT_FILE,
        ACT_META
    } act_t;

    typedef struct packed {
        op_t                  op;
        act_t                 act;
        logic [7:0]           data;
        logic [OFF_W-1:0]     offset;
        logic                 prefix_set;
        logic                 elast;
        logic [SIZE_BITS-1:0] size;
    } q_item_t;

endpackage

/* design/tae_queue.sv */
// short fifo of classified items between front and back end
module tae_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tae_pkg::q_item_t push_item,
    output logic             full,
    input  logic             pop,
    output tae_pkg::q_item_t pop_item,
    output logic             not_empty
);

    localparam int PW = $clog2(tae_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(tae_pkg::QUEUE_DEPTH + 1);

    tae_pkg::q_item_t  slot_reg [tae_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    assign full      = (count_reg == CW'(tae_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* design/tae_front.sv */
// front end: tracks block position, parses header fields on the fly, classifies items
module tae_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    output logic             push,
    output tae_pkg::q_item_t push_item,
    input  logic             q_full
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_CONTENT,
        PH_PAD,
        PH_ENDED
    } phase_t;

    localparam int OW = tae_pkg::OFF_W;
    localparam int SB = tae_pkg::SIZE_BITS;

    phase_t            phase_reg;
    logic [OW-1:0]     off_reg;
    logic              all_zero_reg;
    logic              long_pending_reg;
    logic              await_meta_reg;
    logic [SB-1:0]     bytes_left_reg;
    logic [OW-1:0]     pad_left_reg;
    logic [SB-1:0]     size_reg;
    logic              size_stop_reg;
    logic              size_lead_reg;
    logic [7:0]        type_reg;
    logic              prefix_set_reg;

    logic              accept;
    logic              blk_end;
    logic              zero_eff;
    logic              in_size;
    logic              is_digit;
    logic [SB-1:0]     size_next;
    logic              stop_next;
    logic              lead_next;
    tae_pkg::act_t     act;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign blk_end  = (off_reg == OW'(tae_pkg::BLOCK_BYTES - 1));
    assign zero_eff = all_zero_reg && (s_tdata == 8'h00);
    assign in_size  = (off_reg >= OW'(tae_pkg::SIZE_OFF))
                   && (off_reg < OW'(tae_pkg::SIZE_OFF + tae_pkg::SIZE_DIGITS));
    assign is_digit = (s_tdata >= tae_pkg::CH_ZERO) && (s_tdata <= tae_pkg::CH_SEVEN);

    // octal size field: leading spaces, then digits up to the first other byte
    always_comb
    begin
        size_next = size_reg;
        stop_next = size_stop_reg;
        lead_next = size_lead_reg;
        if (in_size && !size_stop_reg)
        begin
            if (size_lead_reg && (s_tdata == tae_pkg::CH_SPACE))
            begin
                lead_next = 1'b1;
            end
            else if (is_digit)
            begin
                lead_next = 1'b0;
                size_next = {size_reg[SB-4:0], s_tdata[2:0]};
            end
            else
            begin
                stop_next = 1'b1;
            end
        end
    end

    // block decision on the last header byte
    always_comb
    begin
        act = tae_pkg::ACT_NONE;
        if (blk_end)
        begin
            if (await_meta_reg)
            begin
                act = tae_pkg::ACT_META;
            end
            else if (zero_eff)
            begin
                act = tae_pkg::ACT_END;
            end
            else if (long_pending_reg)
            begin
                act = tae_pkg::ACT_LONG;
            end
            else if ((type_reg == 8'h00) || (type_reg == tae_pkg::CH_ZERO))
            begin
                act = tae_pkg::ACT_FILE;
            end
        end
    end

    // queue item
    always_comb
    begin
        push_item.op         = (phase_reg == PH_CONTENT) ? tae_pkg::OP_CONTENT : tae_pkg::OP_HDR;
        push_item.act        = (phase_reg == PH_CONTENT) ? tae_pkg::ACT_NONE : act;
        push_item.data       = s_tdata;
        push_item.offset     = off_reg;
        push_item.prefix_set = prefix_set_reg;
        push_item.elast      = (bytes_left_reg == SB'(1));
        push_item.size       = size_reg;
        push = accept && ((phase_reg == PH_HEADER) || (phase_reg == PH_CONTENT));
    end

    // phase and header tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            off_reg          <= '0;
            all_zero_reg     <= 1'b1;
            long_pending_reg <= 1'b0;
            await_meta_reg   <= 1'b0;
            bytes_left_reg   <= '0;
            pad_left_reg     <= '0;
            size_reg         <= '0;
            size_stop_reg    <= 1'b0;
            size_lead_reg    <= 1'b1;
            type_reg         <= '0;
            prefix_set_reg   <= 1'b0;
        end
        else if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    off_reg <= off_reg + 1'b1;
                    if (off_reg == OW'(tae_pkg::TYPE_OFF))
                    begin
                        type_reg <= s_tdata;
                    end
                    if (off_reg == OW'(tae_pkg::PREFIX_OFF))
                    begin
                        prefix_set_reg <= (s_tdata != 8'h00);
                    end
                    if (blk_end)
                    begin
                        all_zero_reg  <= 1'b1;
                        size_reg      <= '0;
                        size_stop_reg <= 1'b0;
                        size_lead_reg <= 1'b1;
                        case (act)
                            tae_pkg::ACT_META, tae_pkg::ACT_FILE:
                            begin
                                await_meta_reg <= 1'b0;
                                bytes_left_reg <= size_reg;
                                pad_left_reg   <= OW'(0) - size_reg[OW-1:0];
                                phase_reg      <= (size_reg != '0) ? PH_CONTENT : PH_HEADER;
                            end
                            tae_pkg::ACT_END:
                            begin
                                phase_reg <= PH_ENDED;
                            end
                            tae_pkg::ACT_LONG:
                            begin
                                long_pending_reg <= 1'b0;
                                await_meta_reg   <= 1'b1;
                            end
                            default:
                            begin
                                if (type_reg == tae_pkg::CH_LONG)
                                begin
                                    long_pending_reg <= 1'b1;
                                end
                            end
                        endcase
                    end
                    else
                    begin
                        all_zero_reg  <= zero_eff;
                        size_reg      <= size_next;
                        size_stop_reg <= stop_next;
                        size_lead_reg <= lead_next;
                    end
                end
                PH_CONTENT:
                begin
                    bytes_left_reg <= bytes_left_reg - 1'b1;
                    if (bytes_left_reg == SB'(1))
                    begin
                        phase_reg <= (pad_left_reg != '0) ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD:
                begin
                    pad_left_reg <= pad_left_reg - 1'b1;
                    if (pad_left_reg == OW'(1))
                    begin
                        phase_reg <= PH_HEADER;
                    end
                end
                default:
                begin
                    phase_reg <= PH_ENDED;
                end
            endcase
        end
    end

endmodule

/* design/tae_back.sv */
// back end: header store, name assembly and result emission
module tae_back #(
    parameter int NAME_BYTES = tae_pkg::NAME_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  tae_pkg::q_item_t q_item,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [71:0]      m_tdata,
    output logic [2:0]       m_tuser,
    output logic             m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_CHK,
        ST_SLASH,
        ST_START,
        ST_CH_RD,
        ST_CH_ACC,
        ST_CH_OUT
    } state_t;

    typedef enum logic [1:0] {
        SEG_PREFIX,
        SEG_NAME,
        SEG_LONG
    } seg_t;

    localparam int OW  = tae_pkg::OFF_W;
    localparam int SB  = tae_pkg::SIZE_BITS;
    localparam int NLW = $clog2(NAME_BYTES + 1);
    localparam int NAW = $clog2(NAME_BYTES);

    logic [7:0]      hdr_mem  [tae_pkg::BLOCK_BYTES];
    logic [7:0]      name_mem [NAME_BYTES];
    logic [7:0]      hdr_rdata_reg;
    logic [7:0]      name_rdata_reg;

    state_t          state_reg;
    seg_t            seg_reg;
    logic [OW-1:0]   base_reg;
    logic [OW:0]     cnt_reg;
    logic [NLW-1:0]  name_len_reg;
    logic [SB-1:0]   size_reg;
    logic [NLW-1:0]  pos_reg;
    logic [3:0]      j_reg;
    logic [63:0]     acc_reg;

    logic            out_valid_reg;
    logic [1:0]      kind_reg;
    logic [63:0]     payload_reg;
    logic [3:0]      vb_reg;
    logic            elast_reg;
    logic            last_reg;

    logic            can_out;
    logic            out_load;
    logic [OW-1:0]   hdr_raddr;
    logic [NAW-1:0]  name_raddr;
    logic [OW:0]     seg_max;
    logic            room;
    logic            name_we;
    logic [7:0]      name_wdata;
    logic [NLW-1:0]  rem;
    logic [3:0]      chunk_valid;
    logic            chunk_final;

    assign can_out  = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, vb_reg, payload_reg};
    assign m_tuser  = {elast_reg, kind_reg};
    assign m_tlast  = last_reg;

    assign hdr_raddr  = base_reg + cnt_reg[OW-1:0];
    assign name_raddr = NAW'(pos_reg + NLW'(j_reg));
    assign room       = (name_len_reg < NLW'(NAME_BYTES));
    assign rem        = name_len_reg - pos_reg;
    assign chunk_final = (rem <= NLW'(tae_pkg::CHUNK_BYTES));
    assign chunk_valid = chunk_final ? rem[3:0] : 4'(tae_pkg::CHUNK_BYTES);

    // item pop: content and end results need the output register
    assign pop = (state_reg == ST_IDLE) && q_valid
              && (can_out || ((q_item.op == tae_pkg::OP_HDR)
                              && (q_item.act != tae_pkg::ACT_END)));

    // output register loads a new item
    assign out_load = ((state_reg == ST_IDLE) && pop
                       && ((q_item.op == tae_pkg::OP_CONTENT)
                           || (q_item.act == tae_pkg::ACT_END)))
                   || (((state_reg == ST_START) || (state_reg == ST_CH_OUT)) && can_out);

    // copy limit of the current header segment
    always_comb
    begin
        case (seg_reg)
            SEG_PREFIX: seg_max = (OW+1)'(tae_pkg::PREFIX_LEN);
            SEG_NAME:   seg_max = (OW+1)'(tae_pkg::NAME_FIELD_LEN);
            default:    seg_max = (OW+1)'(tae_pkg::BLOCK_BYTES);
        endcase
    end

    // name store write port
    always_comb
    begin
        name_we    = 1'b0;
        name_wdata = tae_pkg::CH_SLASH;
        if ((state_reg == ST_CHK) && (hdr_rdata_reg != 8'h00) && room)
        begin
            name_we    = 1'b1;
            name_wdata = hdr_rdata_reg;
        end
        else if ((state_reg == ST_SLASH) && room)
        begin
            name_we = 1'b1;
        end
    end

    // header store and name store
    always_ff @(posedge clk)
    begin
        if (pop && (q_item.op == tae_pkg::OP_HDR))
        begin
            hdr_mem[q_item.offset] <= q_item.data;
        end
        hdr_rdata_reg <= hdr_mem[hdr_raddr];
        if (name_we)
        begin
            name_mem[name_len_reg[NAW-1:0]] <= name_wdata;
        end
        name_rdata_reg <= name_mem[name_raddr];
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seg_reg       <= SEG_NAME;
            base_reg      <= '0;
            cnt_reg       <= '0;
            name_len_reg  <= '0;
            size_reg      <= '0;
            pos_reg       <= '0;
            j_reg         <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= '0;
            payload_reg   <= '0;
            vb_reg        <= '0;
            elast_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        if (q_item.op == tae_pkg::OP_CONTENT)
                        begin
                            kind_reg      <= tae_pkg::KIND_DATA;
                            payload_reg   <= {56'd0, q_item.data};
                            vb_reg        <= '0;
                            elast_reg     <= q_item.elast;
                            last_reg      <= 1'b1;
                        end
                        else
                        begin
                            case (q_item.act)
                                tae_pkg::ACT_END:
                                begin
                                    kind_reg      <= tae_pkg::KIND_END;
                                    payload_reg   <= '0;
                                    vb_reg        <= '0;
                                    elast_reg     <= 1'b0;
                                    last_reg      <= 1'b1;
                                end
                                tae_pkg::ACT_LONG:
                                begin
                                    name_len_reg <= '0;
                                    seg_reg      <= SEG_LONG;
                                    base_reg     <= '0;
                                    cnt_reg      <= '0;
                                    state_reg    <= ST_COPY;
                                end
                                tae_pkg::ACT_FILE:
                                begin
                                    size_reg     <= q_item.size;
                                    name_len_reg <= '0;
                                    cnt_reg      <= '0;
                                    state_reg    <= ST_COPY;
                                    if (q_item.prefix_set)
                                    begin
                                        seg_reg  <= SEG_PREFIX;
                                        base_reg <= OW'(tae_pkg::PREFIX_OFF);
                                    end
                                    else
                                    begin
                                        seg_reg  <= SEG_NAME;
                                        base_reg <= '0;
                                    end
                                end
                                tae_pkg::ACT_META:
                                begin
                                    size_reg  <= q_item.size;
                                    state_reg <= ST_START;
                                end
                                default:
                                begin
                                    state_reg <= ST_IDLE;
                                end
                            endcase
                        end
                    end
                end
                ST_COPY, ST_CHK:
                begin
                    if (((state_reg == ST_COPY) && (cnt_reg == seg_max))
                        || ((state_reg == ST_CHK) && (hdr_rdata_reg == 8'h00)))
                    begin
                        case (seg_reg)
                            SEG_PREFIX: state_reg <= ST_SLASH;
                            SEG_NAME:   state_reg <= ST_START;
                            default:    state_reg <= ST_IDLE;
                        endcase
                    end
                    else if (state_reg == ST_COPY)
                    begin
                        state_reg <= ST_CHK;
                    end
                    else
                    begin
                        if (room)
                        begin
                            name_len_reg <= name_len_reg + 1'b1;
                        end
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= ST_COPY;
                    end
                end
                ST_SLASH:
                begin
                    if (room)
                    begin
                        name_len_reg <= name_len_reg + 1'b1;
                    end
                    seg_reg   <= SEG_NAME;
                    base_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_COPY;
                end
                ST_START:
                begin
                    if (can_out)
                    begin
                        kind_reg      <= tae_pkg::KIND_START;
                        payload_reg   <= 64'(size_reg);
                        vb_reg        <= '0;
                        elast_reg     <= 1'b0;
                        last_reg      <= 1'b0;
                        pos_reg       <= '0;
                        j_reg         <= '0;
                        acc_reg       <= '0;
                        state_reg     <= ST_CH_RD;
                    end
                end
                ST_CH_RD:
                begin
                    state_reg <= (j_reg == chunk_valid) ? ST_CH_OUT : ST_CH_ACC;
                end
                ST_CH_ACC:
                begin
                    acc_reg[{j_reg[2:0], 3'b000} +: 8] <= name_rdata_reg;
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= ST_CH_RD;
                end
                ST_CH_OUT:
                begin
                    if (can_out)
                    begin
                        kind_reg      <= tae_pkg::KIND_NAME;
                        payload_reg   <= acc_reg;
                        vb_reg        <= chunk_valid;
                        elast_reg     <= chunk_final;
                        last_reg      <= chunk_final;
                        pos_reg       <= pos_reg + NLW'(tae_pkg::CHUNK_BYTES);
                        j_reg         <= '0;
                        acc_reg       <= '0;
                        state_reg     <= chunk_final ? ST_IDLE : ST_CH_RD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/tar_archive_stream_extractor.sv */
// top level of the tar archive stream extractor
//
//   channel   dir  tdata                                  tuser                 tlast
//   s_*       in   [7:0] in_byte                          -                     -
//   m_*       out  [63:0] payload, [67:64] valid_bytes    [1:0] kind,           last
//                                                         [2] entry_last
//
// header, padding and content bytes are taken while the queue has room; the back end
// drains a four-item queue one item a cycle while idle, content and end items only
// when the output register can load; for a file header it copies the name bytes
// from the header store, then emits the start item and reads the name out in chunks
// reset is asynchronous and active low; the stores are not cleared
// a stalled output holds its item while the front end keeps filling the queue
module tar_archive_stream_extractor #(
    parameter int NAME_BYTES = tae_pkg::NAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] payload, [67:64] valid_bytes, rest zero
    output logic [2:0]  m_tuser,   // [1:0] kind, [2] entry_last
    output logic        m_tlast
);

    logic             push;
    tae_pkg::q_item_t push_item;
    logic             q_full;
    logic             pop;
    tae_pkg::q_item_t pop_item;
    logic             q_valid;

    // byte classification
    tae_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    // decoupling queue
    tae_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (q_valid)
    );

    // header decode and result emission
    tae_back #(
        .NAME_BYTES (NAME_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (pop_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* test/tb.sv */
// testbench of the tar archive stream extractor: header, name and content decoding
`timescale 1ns / 1ps

module tb;

    localparam int NB             = tae_pkg::NAME_BYTES_DEF;
    localparam int BLOCK_BYTES    = tae_pkg::BLOCK_BYTES;
    localparam int SIZE_BITS      = tae_pkg::SIZE_BITS;
    localparam int NAME_FIELD_LEN = tae_pkg::NAME_FIELD_LEN;
    localparam int SIZE_OFF       = tae_pkg::SIZE_OFF;
    localparam int SIZE_DIGITS    = tae_pkg::SIZE_DIGITS;
    localparam int TYPE_OFF       = tae_pkg::TYPE_OFF;
    localparam int PREFIX_OFF     = tae_pkg::PREFIX_OFF;
    localparam int PREFIX_LEN     = tae_pkg::PREFIX_LEN;

    localparam logic [7:0] CH_ZERO  = tae_pkg::CH_ZERO;
    localparam logic [7:0] CH_SEVEN = tae_pkg::CH_SEVEN;
    localparam logic [7:0] CH_SPACE = tae_pkg::CH_SPACE;
    localparam logic [7:0] CH_LONG  = tae_pkg::CH_LONG;
    localparam logic [7:0] CH_SLASH = tae_pkg::CH_SLASH;

    localparam logic [1:0] KIND_START = tae_pkg::KIND_START;
    localparam logic [1:0] KIND_NAME  = tae_pkg::KIND_NAME;
    localparam logic [1:0] KIND_DATA  = tae_pkg::KIND_DATA;
    localparam logic [1:0] KIND_END   = tae_pkg::KIND_END;

    // predictor phase
    typedef enum logic [1:0] {
        SB_HEADER,
        SB_CONTENT,
        SB_PAD,
        SB_ENDED
    } sb_phase_t;

    // one expected output item
    typedef struct {
        logic [1:0]  kind;
        logic [63:0] payload;
        logic [3:0]  valid_bytes;
        logic        entry_last;
        logic        last;
    } tar_out_t;

    // predicts extractor output and keeps the pending expectations
    class tar_scoreboard;
        tar_out_t   pending[$];
        int         errors;
        sb_phase_t  ph;
        int         offs;
        logic [7:0] hdr[BLOCK_BYTES];
        logic [7:0] nm[NB];
        bit         all_zero, long_pend, meta_next;
        int         nlen;
        longint     left;
        int         pad;

        function new();
            ph = SB_HEADER; offs = 0; all_zero = 1; long_pend = 0; meta_next = 0;
            nlen = 0; left = 0; pad = 0; errors = 0;
        endfunction

        function void push_res(logic [1:0] k, logic [63:0] p, int v, bit el, bit l);
            tar_out_t r;
            r.kind = k; r.payload = p; r.valid_bytes = v[3:0];
            r.entry_last = el; r.last = l;
            pending.push_back(r);
        endfunction

        function void name_add(logic [7:0] c);
            if (nlen < NB) begin
                nm[nlen] = c;
                nlen++;
            end
        endfunction

        function void name_take(int off, int max);
            for (int i = 0; i < max && off + i < BLOCK_BYTES; i++) begin
                if (hdr[off + i] == 0) break;
                name_add(hdr[off + i]);
            end
        endfunction

        // file start plus name chunks, last flag set on the final one
        function void open_file();
            longint sz;
            int i, chunks, v;
            logic [63:0] p;
            sz = 0;
            i = SIZE_OFF;
            while (i < SIZE_OFF + SIZE_DIGITS && hdr[i] == CH_SPACE) i++;
            while (i < SIZE_OFF + SIZE_DIGITS && hdr[i] >= CH_ZERO && hdr[i] <= CH_SEVEN)
            begin
                sz = (sz << 3) | (hdr[i] - CH_ZERO);
                i++;
            end
            sz = sz & ((64'd1 << SIZE_BITS) - 1);
            left = sz;
            pad = int'((BLOCK_BYTES - (sz % BLOCK_BYTES)) % BLOCK_BYTES);
            push_res(KIND_START, sz, 0, 0, 0);
            chunks = (nlen == 0) ? 1 : (nlen + 7) / 8;
            for (int k = 0; k < chunks; k++) begin
                v = nlen > k * 8 ? nlen - k * 8 : 0;
                if (v > 8) v = 8;
                p = 0;
                for (int j = 0; j < v; j++) p[8*j +: 8] = nm[k*8 + j];
                push_res(KIND_NAME, p, v, k + 1 == chunks, k + 1 == chunks);
            end
            ph = (sz != 0) ? SB_CONTENT : SB_HEADER;
        endfunction

        function void note_input(logic [7:0] b);
            case (ph)
                SB_CONTENT: begin
                    push_res(KIND_DATA, b, 0, left == 1, 1);
                    if (left > 0) left--;
                    if (left == 0) ph = (pad != 0) ? SB_PAD : SB_HEADER;
                end
                SB_PAD: begin
                    if (pad > 0) pad--;
                    if (pad == 0) ph = SB_HEADER;
                end
                SB_HEADER: begin
                    hdr[offs] = b;
                    if (b != 0) all_zero = 0;
                    offs++;
                    if (offs == BLOCK_BYTES) begin
                        offs = 0;
                        if (meta_next) begin
                            meta_next = 0;
                            open_file();
                        end else if (all_zero) begin
                            ph = SB_ENDED;
                            push_res(KIND_END, 0, 0, 0, 1);
                        end else if (long_pend) begin
                            long_pend = 0;
                            nlen = 0;
                            name_take(0, BLOCK_BYTES);
                            meta_next = 1;
                        end else if (hdr[TYPE_OFF] == 0 || hdr[TYPE_OFF] == CH_ZERO) begin
                            nlen = 0;
                            if (hdr[PREFIX_OFF] != 0) begin
                                name_take(PREFIX_OFF, PREFIX_LEN);
                                name_add(CH_SLASH);
                            end
                            name_take(0, NAME_FIELD_LEN);
                            open_file();
                        end else if (hdr[TYPE_OFF] == CH_LONG) begin
                            long_pend = 1;
                        end
                        all_zero = 1;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [1:0] k, logic [63:0] p, logic [3:0] v,
                                   logic el, logic l);
            tar_out_t e;
            if (pending.size() == 0) begin
                $error("unexpected output item kind=%0d", k);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (k !== e.kind) begin
                $error("kind exp %0d got %0d", e.kind, k); errors++;
            end
            if (p !== e.payload) begin
                $error("payload exp %h got %h", e.payload, p); errors++;
            end
            if (v !== e.valid_bytes) begin
                $error("valid_bytes exp %0d got %0d", e.valid_bytes, v); errors++;
            end
            if (el !== e.entry_last) begin
                $error("entry_last exp %0d got %0d", e.entry_last, el); errors++;
            end
            if (l !== e.last) begin
                $error("last exp %0d got %0d", e.last, l); errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n;
    logic        s_tvalid, s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid, m_tready;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    tar_scoreboard sb;
    logic [7:0] blk[BLOCK_BYTES];
    int         out_gap;

    tar_archive_stream_extractor dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one archive byte and wait for its handshake
    task automatic send_byte(logic [7:0] b);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(b);
    endtask

    task automatic send_block();
        for (int i = 0; i < BLOCK_BYTES; i++) send_byte(blk[i]);
    endtask

    // random bytes with a given zero probability in percent
    function automatic logic [7:0] rnd_char(int zpct);
        if ($urandom_range(0, 99) < zpct) return 8'h00;
        return 8'($urandom_range(1, 255));
    endfunction

    // header block with given type, size text and name lengths
    task automatic make_header(logic [7:0] typ, longint sz, int nl, int pl, bit noisy_sz);
        foreach (blk[i]) blk[i] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00;
        for (int i = 0; i < NAME_FIELD_LEN; i++) blk[i] = i < nl ? rnd_char(0) : 8'h00;
        for (int i = 0; i < PREFIX_LEN; i++)
            blk[PREFIX_OFF + i] = i < pl ? rnd_char(0) : 8'h00;
        for (int i = 0; i < 12; i++) blk[SIZE_OFF + i] = 8'h00;
        if (noisy_sz) begin
            for (int i = 0; i < 12; i++) blk[SIZE_OFF + i] = 8'($urandom);
        end else begin
            for (int i = 0; i < SIZE_DIGITS; i++)
                blk[SIZE_OFF + i] = 8'(CH_ZERO + ((sz >> (3 * (10 - i))) & 7));
            if ($urandom_range(0, 3) == 0) blk[SIZE_OFF] = CH_SPACE;
        end
        blk[TYPE_OFF] = typ;
    endtask

    task automatic send_content(longint sz);
        longint padn;
        padn = (BLOCK_BYTES - (sz % BLOCK_BYTES)) % BLOCK_BYTES;
        for (longint i = 0; i < sz + padn; i++) send_byte(8'($urandom));
    endtask

    // plain file entry
    task automatic file_entry(longint sz, int nl, int pl);
        make_header($urandom_range(0, 1) ? CH_ZERO : 8'h00, sz, nl, pl, 0);
        send_block();
        send_content(sz);
    endtask

    // long name entry: 'L' header, name block, metadata block
    task automatic long_entry(longint sz, int nl);
        make_header(CH_LONG, 0, 5, 0, 0);
        send_block();
        foreach (blk[i])
            blk[i] = i < nl ? rnd_char(0) : ($urandom_range(0, 1) ? 8'($urandom) : 8'h00);
        if (nl < BLOCK_BYTES) blk[nl] = 8'h00;
        send_block();
        make_header(8'($urandom), sz, 3, 0, 0);
        send_block();
        send_content(sz);
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    // output side with random stalls, mostly short and a few long
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            out_gap  <= 0;
        end else begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser[1:0], m_tdata[63:0], m_tdata[67:64],
                                m_tuser[2], m_tlast);
            if (out_gap > 0) begin
                out_gap  <= out_gap - 1;
                m_tready <= 1'b0;
            end else if (m_tready && ($urandom_range(0, 2) == 0)) begin
                out_gap  <= gap_len();
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty name, max name with prefix, long names, odd types, bad size
        file_entry(0, 0, 0);
        file_entry(1, NAME_FIELD_LEN, PREFIX_LEN);
        file_entry(512, 7, 0);
        file_entry(513, 9, 3);
        long_entry(3, BLOCK_BYTES);
        long_entry(0, 0);
        make_header(8'h35, 5, 4, 0, 0);
        send_block();
        make_header(8'hFF, 0, 4, 0, 1);
        send_block();
        make_header(CH_ZERO, 0, 10, 0, 1);
        send_block();
        make_header(8'h00, 0, 10, 0, 0);
        for (int i = 0; i < SIZE_DIGITS; i++) blk[SIZE_OFF + i] = (i < 8) ? CH_ZERO : CH_SEVEN;
        send_block();
        send_content(511);

        // random entries
        for (int n = 0; n < 12; n++) begin
            int r;
            r = $urandom_range(0, 9);
            if (r < 6) file_entry($urandom_range(0, 40), $urandom_range(0, NAME_FIELD_LEN),
                                  $urandom_range(0, 2) == 0 ? $urandom_range(0, PREFIX_LEN) : 0);
            else if (r < 8) long_entry($urandom_range(0, 20), $urandom_range(0, 300));
            else begin
                make_header(8'($urandom), 0, 4, 0, 1);
                send_block();
            end
        end

        // archive end, then bytes that must be ignored
        foreach (blk[i]) blk[i] = 8'h00;
        send_block();
        for (int i = 0; i < 20; i++) send_byte(8'($urandom));
        s_tvalid <= 1'b0;
        wait_idle();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #1s;
        $display("tb: failure");
        $finish;
    end

endmodule

/* filelist.f */
design/tae_pkg.sv
design/tae_queue.sv
design/tae_front.sv
design/tae_back.sv
design/tar_archive_stream_extractor.sv
test/tb.sv
